@@ hw/rtl/flph_pkg.sv @@
// Shared types and constants for the FNV-1a linear-probe key/value table.
// No dependencies; imported by flph_hash, flph_table and the top level.
package flph_pkg;

  localparam int KEY_W   = 64;
  localparam int LEN_W   = 4;
  localparam int VALUE_W = 64;
  localparam int HASH_W  = 32;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

  typedef enum logic {
    OP_SET = 1'b0,
    OP_GET = 1'b1
  } op_t;

  typedef enum logic {
    ST_DONE = 1'b0,
    ST_FULL = 1'b1
  } status_t;

  // One stored slot, less its used bit.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [LEN_W-1:0]   len;
    logic [VALUE_W-1:0] value;
  } entry_t;

endpackage

@@ hw/rtl/flph_hash.sv @@
// Serial FNV-1a hash unit: one key byte per cycle through a shared multiplier.
// Depends on flph_pkg for widths and the FNV constants.
module flph_hash import flph_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [KEY_W-1:0]  key,
  input  logic [LEN_W-1:0]  len,
  output logic              done,
  output logic [HASH_W-1:0] hash
);

  logic              run;
  logic [LEN_W-1:0]  byte_idx;
  logic [HASH_W-1:0] h;
  logic [HASH_W-1:0] h_next;
  logic [7:0]        cur_byte;

  always_comb begin
    cur_byte = key[{byte_idx[2:0], 3'b000} +: 8];
    h_next   = (h ^ {{(HASH_W-8){1'b0}}, cur_byte}) * FNV_PRIME;
  end

  assign done = run && (byte_idx == len);
  assign hash = h;

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      byte_idx <= '0;
    end else if (start) begin
      run      <= 1'b1;
      byte_idx <= '0;
    end else if (run) begin
      if (byte_idx == len) begin
        run <= 1'b0;
      end else begin
        byte_idx <= byte_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      h <= FNV_BASIS;
    end else if (run && (byte_idx != len)) begin
      h <= h_next;
    end
  end

endmodule

@@ hw/rtl/flph_table.sv @@
// Slot storage: used-bit memory with a clearing pass after reset, and an
// entry memory (key, length, value). Registered reads. Depends on flph_pkg.
module flph_table import flph_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [$clog2(CAPACITY)-1:0] rd_addr,
  output logic                        rd_used,
  output entry_t                      rd_entry,
  input  logic                        wr_en,
  input  logic [$clog2(CAPACITY)-1:0] wr_addr,
  input  entry_t                      wr_entry,
  output logic                        ready
);

  localparam int AW = $clog2(CAPACITY);

  logic          used_mem [CAPACITY];
  entry_t        entry_mem [CAPACITY];
  logic          clearing;
  logic [AW-1:0] clr_idx;

  assign ready = !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == AW'(CAPACITY - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      used_mem[clr_idx] <= 1'b0;
    end else if (wr_en) begin
      used_mem[wr_addr] <= 1'b1;
    end
    rd_used <= used_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_entry;
    end
    rd_entry <= entry_mem[rd_addr];
  end

endmodule

@@ hw/rtl/fnv_linear_probe_hash_table.sv @@
// Top level of the FNV-1a open-addressing key/value table with linear probing.
// Depends on flph_pkg, flph_hash and flph_table.
//
//  channel   ports                                         handshake
//  -------   --------------------------------------------  -------------------------
//  command   opcode, key_bytes, key_length, value_in       taken when start && !busy
//  result    found, value_out, status                      one-cycle strobe on done
//
// An item goes from the accept cycle through the serial hash unit (length
// saturated at MAX_KEY_BYTES), then through a registered memory read and a
// compare for each probed slot.
// done rises the cycle after the last compare, and busy is already low then.
// After reset a clearing pass over the used bits runs with busy high
// throughout. busy stays high while an item is at work. The receiver
// cannot stall: each result is shown for exactly one cycle.
module fnv_linear_probe_hash_table import flph_pkg::*; #(
  parameter int CAPACITY      = 64,
  parameter int MAX_KEY_BYTES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic [KEY_W-1:0]   key_bytes,
  input  logic [LEN_W-1:0]   key_length,
  input  logic [VALUE_W-1:0] value_in,
  output logic               done,
  output logic               found,
  output logic [VALUE_W-1:0] value_out,
  output logic               status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY / 2 + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK
  } state_t;

  state_t             state;
  op_t                op_q;
  logic [KEY_W-1:0]   key_q;
  logic [LEN_W-1:0]   len_q;
  logic [VALUE_W-1:0] value_q;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      probe_cnt;
  logic [CW-1:0]      entry_count;

  logic               accept;
  logic [LEN_W-1:0]   len_sat;
  logic [KEY_W-1:0]   key_masked;
  logic               hash_done;
  logic [HASH_W-1:0]  hash;
  logic               rd_used;
  entry_t             rd_entry;
  logic               tbl_ready;
  logic               match;
  logic               finish;
  logic               insert;
  logic               wr_en;
  entry_t             wr_entry;

  assign busy   = (state != S_IDLE) || !tbl_ready;
  assign accept = start && !busy;

  // Saturate the length and drop bytes past it.
  always_comb begin
    len_sat = (key_length > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES) : key_length;
    for (int i = 0; i < KEY_W / 8; i++) begin
      key_masked[8*i +: 8] = (LEN_W'(i) < len_sat) ? key_bytes[8*i +: 8] : 8'h00;
    end
  end

  flph_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .key   (key_q),
    .len   (len_q),
    .done  (hash_done),
    .hash  (hash)
  );

  flph_table #(
    .CAPACITY (CAPACITY)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (idx),
    .rd_used  (rd_used),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (idx),
    .wr_entry (wr_entry),
    .ready    (tbl_ready)
  );

  always_comb begin
    match    = rd_used && (rd_entry.len == len_q) && (rd_entry.key == key_q);
    finish   = !rd_used || match || (probe_cnt == AW'(CAPACITY - 1));
    insert   = (op_q == OP_SET) && !match && !rd_used &&
               (entry_count < CW'(CAPACITY / 2));
    wr_en    = (state == S_CHECK) && (op_q == OP_SET) && (match || insert);
    wr_entry = '{key: key_q, len: len_q, value: value_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (finish) begin
            state <= S_IDLE;
            done  <= 1'b1;
            if (insert) begin
              entry_count <= entry_count + 1'b1;
            end
          end else begin
            state <= S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload, probe and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op_t'(opcode);
      key_q   <= key_masked;
      len_q   <= len_sat;
      value_q <= value_in;
    end
    if (state == S_HASH && hash_done) begin
      idx       <= hash[AW-1:0];
      probe_cnt <= '0;
    end
    if (state == S_CHECK) begin
      if (finish) begin
        found     <= match;
        value_out <= (op_q == OP_GET && match) ? rd_entry.value : '0;
        status    <= (op_q == OP_SET && !match && !insert) ? ST_FULL : ST_DONE;
      end else begin
        idx       <= idx + 1'b1;
        probe_cnt <= probe_cnt + 1'b1;
      end
    end
  end

  a_done_after_check: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_CHECK)
    else $error("result strobe without a final compare");

  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> !found)
    else $error("refused set reports a found key");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(CAPACITY / 2))
    else $error("entry count above load limit");

  a_accept_hash: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_HASH)
    else $error("accepted word did not enter hashing");

endmodule

@@ sim/fnv_linear_probe_hash_table_tb.sv @@
// Self-checking testbench for fnv_linear_probe_hash_table: directed and random set/get words,
// a mirror of the table that predicts each reply, and a cycle watchdog.
// Depends on flph_pkg and the RTL of fnv_linear_probe_hash_table.
module fnv_linear_probe_hash_table_tb import flph_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS         = 64;
  localparam int MAX_KEY_BYTES = 8;
  localparam int RANDOM_WORDS  = 1430;
  localparam int POOL_MAX      = 96;
  localparam int TAIL_CYCLES   = 120;
  localparam int CYCLE_LIMIT   = 800000;

  typedef struct {
    logic               found;
    logic [VALUE_W-1:0] value;
    status_t            status;
  } reply_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } stored_key_t;

  // Mirror of the slot array; predicts the reply of each accepted word.
  class table_mirror;
    logic               used   [SLOTS];
    logic [KEY_W-1:0]   keys   [SLOTS];
    logic [LEN_W-1:0]   lens   [SLOTS];
    logic [VALUE_W-1:0] values [SLOTS];
    int unsigned        entries;
    reply_t             pending_replies[$];
    int                 mismatches;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      entries    = 0;
      mismatches = 0;
    endfunction

    static function logic [LEN_W-1:0] clip_len(logic [LEN_W-1:0] len);
      return (len > MAX_KEY_BYTES) ? LEN_W'(MAX_KEY_BYTES) : len;
    endfunction

    static function logic [KEY_W-1:0] len_mask(logic [LEN_W-1:0] len);
      if (len >= MAX_KEY_BYTES) return '1;
      return (64'd1 << (8 * len)) - 64'd1;
    endfunction

    function logic [HASH_W-1:0] fnv_hash(logic [KEY_W-1:0] key, logic [LEN_W-1:0] len);
      logic [HASH_W-1:0] h;
      int                i;
      h = FNV_BASIS;
      for (i = 0; i < len; i++) begin
        h = h ^ {24'd0, key[8*i +: 8]};
        h = h * FNV_PRIME;
      end
      return h;
    endfunction

    function void note_command(op_t op, logic [KEY_W-1:0] key, logic [LEN_W-1:0] len,
                               logic [VALUE_W-1:0] value);
      logic [LEN_W-1:0] n;
      logic [KEY_W-1:0] k;
      int unsigned      slot;
      int               probes;
      bit               hit;
      reply_t           r;
      n    = clip_len(len);
      k    = key & len_mask(n);
      slot = fnv_hash(k, n) & (SLOTS - 1);
      hit  = 1'b0;
      for (probes = 0; probes < SLOTS; probes++) begin
        if (!used[slot]) break;
        if (lens[slot] == n && keys[slot] == k) begin
          hit = 1'b1;
          break;
        end
        slot = (slot + 1) % SLOTS;
      end
      r.found  = hit;
      r.value  = '0;
      r.status = ST_DONE;
      if (op == OP_GET) begin
        if (hit) r.value = values[slot];
      end else if (hit) begin
        values[slot] = value;
      end else if (entries >= SLOTS / 2 || used[slot]) begin
        r.status = ST_FULL;
      end else begin
        used[slot]   = 1'b1;
        keys[slot]   = k;
        lens[slot]   = n;
        values[slot] = value;
        entries++;
      end
      pending_replies.push_back(r);
    endfunction

    task report(string field, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
      $display("%0t mismatch on %s: got %h, want %h", $time, field, got, want);
      mismatches++;
    endtask

    task check_reply(logic got_found, logic [VALUE_W-1:0] got_value, logic got_status);
      reply_t r;
      if (pending_replies.size() == 0) begin
        report("unexpected reply", got_value, '0);
        return;
      end
      r = pending_replies.pop_front();
      if (got_found !== r.found) report("found", got_found, r.found);
      if (got_value !== r.value) report("value_out", got_value, r.value);
      if (got_status !== r.status) report("status", got_status, r.status);
    endtask
  endclass

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               start      = 1'b0;
  logic               opcode     = OP_SET;
  logic [KEY_W-1:0]   key_bytes  = '0;
  logic [LEN_W-1:0]   key_length = '0;
  logic [VALUE_W-1:0] value_in   = '0;
  logic               busy;
  logic               done;
  logic               found;
  logic [VALUE_W-1:0] value_out;
  logic               status;

  table_mirror mirror = new();
  stored_key_t key_pool[$];
  int unsigned cycle_count = 0;

  fnv_linear_probe_hash_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .opcode    (opcode),
    .key_bytes (key_bytes),
    .key_length(key_length),
    .value_in  (value_in),
    .done      (done),
    .found     (found),
    .value_out (value_out),
    .status    (status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin
    if (!rst && done) mirror.check_reply(found, value_out, status);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Leave start high on return so a following word can go out back to back.
  task automatic issue_word(op_t op, logic [KEY_W-1:0] key, logic [LEN_W-1:0] len,
                            logic [VALUE_W-1:0] value);
    start      <= 1'b1;
    opcode     <= op;
    key_bytes  <= key;
    key_length <= len;
    value_in   <= value;
    do @(posedge clk); while (busy);
    mirror.note_command(op, key, len, value);
  endtask

  task automatic hold_off(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_replies();
    start <= 1'b0;
    do @(posedge clk); while (mirror.pending_replies.size() != 0);
  endtask

  // Mostly revisit known keys with junk past their length; now and then a fresh key.
  task automatic issue_random_word();
    stored_key_t      k;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] junk;
    logic [LEN_W-1:0] len;
    op_t              op;
    int               b;
    op   = op_t'(1'($urandom_range(0, 1)));
    junk = {$urandom, $urandom};
    if (key_pool.size() == 0 || $urandom_range(0, 99) < 20) begin
      len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(9, 15))
                                         : LEN_W'($urandom_range(0, 8));
      key = junk;
      for (b = 0; b < 8; b++)
        if ($urandom_range(0, 3) == 0) key[8*b +: 8] = 8'h00;
      k.len = table_mirror::clip_len(len);
      k.key = key & table_mirror::len_mask(k.len);
      if (key_pool.size() < POOL_MAX) key_pool.push_back(k);
      else key_pool[$urandom_range(0, POOL_MAX - 1)] = k;
    end else begin
      k   = key_pool[$urandom_range(0, key_pool.size() - 1)];
      len = k.len;
      if (len == MAX_KEY_BYTES && $urandom_range(0, 2) == 0)
        len = LEN_W'($urandom_range(9, 15));
      key = k.key | (junk & ~table_mirror::len_mask(k.len));
    end
    issue_word(op, key, len, {$urandom, $urandom});
  endtask

  initial begin
    int sent;
    int burst;
    int i;
    bit mid_drained;
    sent        = 0;
    mid_drained = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty key, saturated length, zero bytes inside keys, junk past the length
    issue_word(OP_GET, 64'h0, 4'd0, 64'h0);
    issue_word(OP_SET, '1, 4'd0, '1);
    issue_word(OP_GET, 64'h0123_4567_89ab_cdef, 4'd0, '0);
    issue_word(OP_SET, '1, 4'd8, '0);
    issue_word(OP_GET, '1, 4'd15, '1);
    issue_word(OP_GET, 64'h00ff_ffff_ffff_ffff, 4'd8, '0);
    issue_word(OP_SET, 64'hffff_ff00, 4'd1, 64'h5555_5555_5555_5555);
    issue_word(OP_GET, 64'h0, 4'd2, '0);
    issue_word(OP_SET, 64'h0, 4'd2, 64'haaaa_aaaa_aaaa_aaaa);
    issue_word(OP_GET, 64'hdead_be00, 4'd1, '0);
    issue_word(OP_GET, 64'h1234_0000, 4'd2, '0);
    issue_word(OP_SET, 64'h0, 4'd0, 64'h0f0f_0f0f_0f0f_0f0f);
    issue_word(OP_GET, '1, 4'd0, '0);
    issue_word(OP_SET, 64'h0807_0605_0403_0201, 4'd8, 64'h8000_0000_0000_0001);
    issue_word(OP_GET, 64'h0807_0605_0403_0201, 4'd7, '0);
    issue_word(OP_GET, 64'hff07_0605_0403_0201, 4'd7, '0);
    issue_word(OP_SET, 64'h0807_0605_0403_0201, 4'd9, 64'h7fff_ffff_ffff_fffe);
    issue_word(OP_GET, 64'h0807_0605_0403_0201, 4'd8, '0);
    issue_word(OP_GET, 64'h0807_0605_0403_0201, 4'd15, '0);
    issue_word(OP_SET, 64'h0807_0605_0403_0201, 4'd7, 64'h1);
    issue_word(OP_GET, 64'h0007_0605_0403_0201, 4'd7, '0);
    wait_for_replies();

    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 40);
      for (i = 0; i < burst && sent < RANDOM_WORDS; i++) begin
        issue_random_word();
        sent++;
      end
      if (!mid_drained && sent >= RANDOM_WORDS / 2) begin
        wait_for_replies();
        mid_drained = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        hold_off($urandom_range(1, 24));
      end
    end
    start <= 1'b0;

    while (mirror.pending_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.pending_replies.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/flph_pkg.sv
hw/rtl/flph_hash.sv
hw/rtl/flph_table.sv
hw/rtl/fnv_linear_probe_hash_table.sv
sim/fnv_linear_probe_hash_table_tb.sv
